// ===== design/tlbpt_pkg.sv =====
// Package for the TLB and page-table translator.
// Holds sizes, the controller state type and the command/status structs.
package tlbpt_pkg;
    localparam int TlbEntries = 16;
    localparam int TlbIdxW    = 4;
    localparam int PageCount  = 256;
    localparam int PageW      = 8;
    localparam int FrameW     = 8;
    localparam int CountW     = 16;
    localparam int FillW      = 9;
    localparam logic [FillW-1:0]  MaxFrames = 9'd256;
    localparam logic [CountW-1:0] CountMax  = '1;

    typedef enum logic [3:0] {
        t_idle_s  = 4'd0,
        t_clear_s = 4'd1,
        t_rd_s    = 4'd2,
        t_look_s  = 4'd3,
        t_scan_s  = 4'd4,
        t_evict_s = 4'd5,
        t_out_s   = 4'd6
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic read_page;
        logic decide;
        logic scan_start;
        logic scan_step;
        logic evict;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic tlb_hit;
        logic need_scan;
        logic scan_done;
    } t_status;
endpackage

// ===== design/tlbpt_if.sv =====
// Valid/ready channel interfaces for the translator.
// Depends on nothing but the port widths.
interface tlbpt_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] virtual_address;
    modport source (output valid, output virtual_address, input ready);
    modport sink (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] physical_address;
    logic        tlb_hit;
    logic        page_fault;
    modport source (output valid, output physical_address, output tlb_hit,
                    output page_fault, input ready);
    modport sink (input valid, input physical_address, input tlb_hit,
                  input page_fault, output ready);
endinterface

interface tlbpt_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] frames_in_use;
    modport source (output valid, output frames_in_use, input ready);
    modport sink (input valid, input frames_in_use, output ready);
endinterface

// ===== design/tlbpt_ctrl.sv =====
// Controller state machine of the translator.
// Uses tlbpt_pkg; drives the datapath through t_cmd and reads t_status.
module tlbpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_busy,
    input  tlbpt_pkg::t_status i_status,
    output tlbpt_pkg::t_cmd    o_cmd
);
    tlbpt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlbpt_pkg::t_clear_s;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlbpt_pkg::t_clear_s: if (i_status.clear_done) n_state = tlbpt_pkg::t_idle_s;
            tlbpt_pkg::t_idle_s:  if (i_in_valid) n_state = tlbpt_pkg::t_rd_s;
            tlbpt_pkg::t_rd_s:    n_state = tlbpt_pkg::t_look_s;
            tlbpt_pkg::t_look_s: begin
                if (i_status.need_scan) n_state = tlbpt_pkg::t_scan_s;
                else n_state = tlbpt_pkg::t_out_s;
            end
            tlbpt_pkg::t_scan_s:  if (i_status.scan_done) n_state = tlbpt_pkg::t_evict_s;
            tlbpt_pkg::t_evict_s: n_state = tlbpt_pkg::t_out_s;
            tlbpt_pkg::t_out_s:   if (!i_out_busy) n_state = tlbpt_pkg::t_idle_s;
            default:              n_state = tlbpt_pkg::t_idle_s;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tlbpt_pkg::t_clear_s: o_cmd.clear_step = 1'b1;
            tlbpt_pkg::t_idle_s: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tlbpt_pkg::t_rd_s:    o_cmd.read_page = 1'b1;
            tlbpt_pkg::t_look_s: begin
                o_cmd.decide = 1'b1;
                o_cmd.scan_start = i_status.need_scan;
            end
            tlbpt_pkg::t_scan_s:  o_cmd.scan_step = 1'b1;
            tlbpt_pkg::t_evict_s: o_cmd.evict = 1'b1;
            tlbpt_pkg::t_out_s:   o_cmd.out_load = !i_out_busy;
            default: ;
        endcase
    end
endmodule

// ===== design/tlbpt_datapath.sv =====
// Datapath of the translator: TLB, page table memories, scan and output register.
// Uses tlbpt_pkg; commanded by tlbpt_ctrl.
module tlbpt_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlbpt_pkg::t_cmd    i_cmd,
    output tlbpt_pkg::t_status o_status,
    input  logic [15:0]        i_va,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [15:0]        o_pa,
    output logic               o_hit,
    output logic               o_fault
);
    localparam int PW = tlbpt_pkg::PageW;
    localparam int FW = tlbpt_pkg::FrameW;
    localparam int CW = tlbpt_pkg::CountW;
    localparam int NW = tlbpt_pkg::FillW;
    localparam int TE = tlbpt_pkg::TlbEntries;
    localparam int IW = tlbpt_pkg::TlbIdxW;
    localparam int PC = tlbpt_pkg::PageCount;

    logic [NW-1:0] r_cfg;
    logic [NW-1:0] r_filled;
    logic [TE-1:0] r_tlb_v;
    logic [PW-1:0] r_tlb_page [TE];
    logic [FW-1:0] r_tlb_frame [TE];
    logic [IW-1:0] r_tlb_next;
    logic [PC-1:0] r_pvalid;
    logic [FW-1:0] r_pframe_mem [PC];
    logic [CW-1:0] r_count_mem [PC];

    logic [PW-1:0] r_page;
    logic [7:0]    r_off;
    logic [FW-1:0] r_pf_rd;
    logic [CW-1:0] r_cnt_rd;
    logic [FW-1:0] r_frame;
    logic          r_hit, r_fault;
    logic [NW-1:0] r_idx;
    logic          r_rd_v;
    logic [PW-1:0] r_rd_pg;
    logic [CW-1:0] r_scan_cnt;
    logic          r_found;
    logic [PW-1:0] r_victim;
    logic [CW-1:0] r_best, r_top;
    logic [FW-1:0] r_vframe;
    logic          r_out_v;
    logic [15:0]   r_pa;
    logic          r_o_hit, r_o_fault;

    logic          tlb_match;
    logic [FW-1:0] tlb_frame;
    logic [NW-1:0] limit;
    logic          free_frame;
    logic [PW-1:0] mem_addr;
    logic          mem_we_cnt;
    logic [CW-1:0] mem_wd_cnt;
    logic          mem_we_frame;
    logic [FW-1:0] mem_wd_frame;
    logic [PW-1:0] mem_wa;

    always_comb begin
        tlb_match = 1'b0;
        tlb_frame = '0;
        for (int i = TE - 1; i >= 0; i--) begin
            if (r_tlb_v[i] && r_tlb_page[i] == r_page) begin
                tlb_match = 1'b1;
                tlb_frame = r_tlb_frame[i];
            end
        end
    end

    always_comb begin
        limit = r_cfg;
        if (r_cfg == '0) limit = NW'(1);
        if (r_cfg > tlbpt_pkg::MaxFrames) limit = tlbpt_pkg::MaxFrames;
    end
    assign free_frame = r_filled < limit;

    assign o_status.clear_done = r_idx[PW];
    assign o_status.tlb_hit    = tlb_match;
    assign o_status.need_scan  = !tlb_match && !r_pvalid[r_page] && !free_frame;
    assign o_status.scan_done  = r_rd_v && r_idx[PW];

    always_comb begin
        mem_addr = r_idx[PW-1:0];
        if (i_cmd.read_page) mem_addr = r_page;
    end

    always_comb begin
        mem_we_cnt = 1'b0;
        mem_wd_cnt = r_cnt_rd;
        mem_we_frame = 1'b0;
        mem_wd_frame = r_filled[FW-1:0];
        mem_wa = r_page;
        if (i_cmd.clear_step) begin
            mem_we_cnt = 1'b1;
            mem_wd_cnt = '0;
            mem_wa = r_idx[PW-1:0];
        end else if (i_cmd.decide && !tlb_match) begin
            if (r_pvalid[r_page]) begin
                mem_we_cnt = r_cnt_rd != tlbpt_pkg::CountMax;
                mem_wd_cnt = r_cnt_rd + CW'(1);
            end else if (free_frame) begin
                mem_we_frame = 1'b1;
            end
        end else if (i_cmd.evict) begin
            mem_we_cnt = 1'b1;
            mem_wd_cnt = r_top;
            mem_we_frame = 1'b1;
            mem_wd_frame = r_found ? r_vframe : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we_cnt) r_count_mem[mem_wa] <= mem_wd_cnt;
        if (mem_we_frame) r_pframe_mem[mem_wa] <= mem_wd_frame;
        r_cnt_rd <= r_count_mem[mem_addr];
        r_pf_rd  <= r_pframe_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= tlbpt_pkg::MaxFrames;
            r_filled   <= '0;
            r_tlb_v    <= '0;
            r_tlb_next <= '0;
            r_pvalid   <= '0;
            r_idx      <= '0;
            r_rd_v     <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            r_rd_v <= i_cmd.scan_step && !r_idx[PW];
            if (i_cmd.clear_step) r_idx <= r_idx + NW'(1);
            if (i_cmd.load) begin
                r_page <= i_va[15:8];
                r_off  <= i_va[7:0];
            end
            if (i_cmd.decide) begin
                r_hit   <= tlb_match;
                r_fault <= !tlb_match && !r_pvalid[r_page];
                if (tlb_match) r_frame <= tlb_frame;
                else if (r_pvalid[r_page]) r_frame <= r_pf_rd;
                else if (free_frame) begin
                    r_frame  <= r_filled[FW-1:0];
                    r_filled <= r_filled + NW'(1);
                    r_pvalid[r_page] <= 1'b1;
                end
                if (i_cmd.scan_start) begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_top   <= '0;
                end
            end
            if (i_cmd.scan_step) begin
                if (!r_idx[PW]) begin
                    r_idx   <= r_idx + NW'(1);
                    r_rd_pg <= r_idx[PW-1:0];
                end
                if (r_rd_v) begin
                    if (r_cnt_rd > r_top) r_top <= r_cnt_rd;
                    if (r_pvalid[r_rd_pg] && (!r_found || r_cnt_rd < r_best)) begin
                        r_found  <= 1'b1;
                        r_victim <= r_rd_pg;
                        r_best   <= r_cnt_rd;
                        r_vframe <= r_pf_rd;
                    end
                end
            end
            if (i_cmd.evict) begin
                r_frame <= r_found ? r_vframe : '0;
                if (r_found) begin
                    for (int i = 0; i < TE; i++) begin
                        if (r_tlb_page[i] == r_victim) r_tlb_v[i] <= 1'b0;
                    end
                end
                r_pvalid <= (r_pvalid & ~(r_found ? (PC'(1) << r_victim) : PC'(0)))
                            | (PC'(1) << r_page);
            end
            if (i_cmd.out_load) begin
                r_tlb_v[r_tlb_next]     <= 1'b1;
                r_tlb_page[r_tlb_next]  <= r_page;
                r_tlb_frame[r_tlb_next] <= r_frame;
                r_tlb_next <= r_tlb_next + IW'(1);
                r_pa      <= {r_frame, r_off};
                r_o_hit   <= r_hit;
                r_o_fault <= r_fault;
                r_out_v   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_pa        = r_pa;
    assign o_hit       = r_o_hit;
    assign o_fault     = r_o_fault;
endmodule

// ===== design/tlb_page_table_translator_top.sv =====
// Top level of the TLB and page-table translator.
// Uses tlbpt_pkg, the channel interfaces, tlbpt_ctrl and tlbpt_datapath.
//
// Each word on the input channel carries a virtual address; exactly one word
// leaves on the output channel for it, with the physical address and the hit
// and fault flags. The configuration channel writes the frame count; it is
// always ready and should be used only while the block is idle.
// A TLB hit, a resident page or a fill of a free frame passes through the read,
// lookup and output states before the result enters the output register.
// A fault with eviction scans all 256 page counters through the single read
// port of the page memories, then passes through the evict and output states.
// One word is in flight at a time; the next is accepted once the result has
// entered the output register, which holds it while the receiver stalls.
// After reset the block clears the 256 use counters, one a cycle, and accepts
// no word until the clear is done.
module tlb_page_table_translator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tlbpt_in_if.sink     in_ch,
    tlbpt_out_if.source  out_ch,
    tlbpt_cfg_if.sink    cfg_ch
);
    tlbpt_pkg::t_cmd    cmd;
    tlbpt_pkg::t_status status;

    assign cfg_ch.ready = 1'b1;

    tlbpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_out_busy (out_ch.valid && !out_ch.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tlbpt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_va        (in_ch.virtual_address),
        .i_cfg_we    (cfg_ch.valid),
        .i_cfg_data  (cfg_ch.frames_in_use),
        .i_out_ready (out_ch.ready),
        .o_out_valid (out_ch.valid),
        .o_pa        (out_ch.physical_address),
        .o_hit       (out_ch.tlb_hit),
        .o_fault     (out_ch.page_fault)
    );
endmodule
